>>> src/tun_pkg.sv
package tun_pkg;

	localparam int CW = 16;          // vertex coordinate width
	localparam int F  = 14;          // fraction bits of the normal
	localparam int OW = F + 2;       // normal component width
	localparam int DW = CW + 1;      // edge difference width
	localparam int PW = 2 * DW;      // product width
	localparam int MW = PW;          // cross term magnitude width
	localparam int NW = 31;          // normalized magnitude width
	localparam int SW = 64;          // sum of squares width
	localparam int RW = 32;          // root width
	localparam int RRW = RW + 2;     // root remainder width
	localparam int QW = F + 1;       // quotient width
	localparam int DVW = NW + F + 2; // divider remainder width
	localparam int NSTG = 6;         // normalizer shift stages: 32,16,8,4,2,1

	localparam logic [QW-1:0] ONE = QW'(1) << F;

	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] az;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by_coord;
		logic signed [CW-1:0] bz;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] cz;
	} tri_t;

	typedef struct packed {
		logic signed [OW-1:0] nx;
		logic signed [OW-1:0] ny;
		logic signed [OW-1:0] nz;
		logic                 degenerate;
	} nrm_t;

	typedef struct packed {
		logic                   valid;
		logic [2:0]             neg;
		logic [2:0][MW-1:0]     mag;
	} norm_t;

	typedef struct packed {
		logic                   valid;
		logic                   degen;
		logic [2:0]             neg;
		logic [2:0][NW-1:0]     m;
		logic [SW-1:0]          s;
		logic [RRW-1:0]         r;
		logic [RW-1:0]          q;
	} sqrt_t;

	typedef struct packed {
		logic                   valid;
		logic                   degen;
		logic [2:0]             neg;
		logic [RW-1:0]          len;
		logic [2:0][DVW-1:0]    rem;
		logic [2:0][QW-1:0]     quo;
	} div_t;

endpackage

>>> src/tun_norm_cell.sv
module tun_norm_cell #(
	parameter int SHIFT = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  tun_pkg::norm_t d,
	output tun_pkg::norm_t q
);

	logic [tun_pkg::MW-1:0] any;
	logic                   sh;

	assign any = d.mag[0] | d.mag[1] | d.mag[2];
	assign sh  = (any[tun_pkg::MW-1 -: SHIFT] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.neg   <= d.neg;
			for (int i = 0; i < 3; i++) begin
				q.mag[i] <= sh ? (d.mag[i] << SHIFT) : d.mag[i];
			end
		end
	end

endmodule

>>> src/tun_sqrt_cell.sv
module tun_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  tun_pkg::sqrt_t d,
	output tun_pkg::sqrt_t q
);

	logic [tun_pkg::RRW+1:0] r2;
	logic [tun_pkg::RRW+1:0] trial;
	logic                    take;

	// one root bit per cell: bring down two radicand bits, try (root<<2)|1
	assign r2    = {d.r, d.s[tun_pkg::SW-1 -: 2]};
	assign trial = (tun_pkg::RRW+2)'({d.q, 2'b01});
	assign take  = (r2 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.degen <= d.degen;
			q.neg   <= d.neg;
			q.m     <= d.m;
			q.s     <= d.s << 2;
			q.r     <= take ? tun_pkg::RRW'(r2 - trial) : tun_pkg::RRW'(r2);
			q.q     <= {d.q[tun_pkg::RW-2:0], take};
		end
	end

endmodule

>>> src/tun_div_cell.sv
module tun_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  tun_pkg::div_t d,
	output tun_pkg::div_t q
);

	logic [tun_pkg::DVW-1:0] dsr;
	logic [2:0]              take;

	// divisor sits at the top quotient weight; the remainder moves up instead
	assign dsr = tun_pkg::DVW'({d.len, {tun_pkg::F{1'b0}}});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			take[i] = (d.rem[i] >= dsr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.degen <= d.degen;
			q.neg   <= d.neg;
			q.len   <= d.len;
			for (int i = 0; i < 3; i++) begin
				q.rem[i] <= (take[i] ? (d.rem[i] - dsr) : d.rem[i]) << 1;
				q.quo[i] <= {d.quo[i][tun_pkg::QW-2:0], take[i]};
			end
		end
	end

endmodule

>>> src/triangle_unit_normal.sv
// Unit face normal of a triangle. Each item on tri carries three Q7.8 vertices;
// norm returns N = (C-A) x (B-A) scaled to unit length in Q1.14, rounded to
// nearest, with degenerate set and zero components when N is zero. The block
// is a fixed pipeline that takes one item every cycle unless it is held. Its stages:
// edge differences, products, cross terms, six normalizer shift cells, squares,
// sum, 32 square-root cells (one root bit each), divider setup, 15 divider
// cells (one quotient bit each, three lanes) and the output register. The whole
// pipe holds while a result waits and norm_ready is low.
module triangle_unit_normal (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tri_valid,
	output logic          tri_ready,
	input  tun_pkg::tri_t tri_data,
	output logic          norm_valid,
	input  logic          norm_ready,
	output tun_pkg::nrm_t norm_data
);

	localparam int DW = tun_pkg::DW;
	localparam int PW = tun_pkg::PW;
	localparam int MW = tun_pkg::MW;
	localparam int NW = tun_pkg::NW;
	localparam int SW = tun_pkg::SW;
	localparam int RW = tun_pkg::RW;
	localparam int QW = tun_pkg::QW;
	localparam int OW = tun_pkg::OW;
	localparam int DVW = tun_pkg::DVW;

	logic en;
	assign en        = !norm_valid || norm_ready;
	assign tri_ready = en;

	// stage 1: edges
	logic                 v_s1;
	logic signed [DW-1:0] ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= tri_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= DW'(tri_data.bx) - DW'(tri_data.ax);
			uy_s1 <= DW'(tri_data.by_coord) - DW'(tri_data.ay);
			uz_s1 <= DW'(tri_data.bz) - DW'(tri_data.az);
			vx_s1 <= DW'(tri_data.cx) - DW'(tri_data.ax);
			vy_s1 <= DW'(tri_data.cy) - DW'(tri_data.ay);
			vz_s1 <= DW'(tri_data.cz) - DW'(tri_data.az);
		end
	end

	// stage 2: products
	logic                 v_s2;
	logic signed [PW-1:0] p_s2 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= uz_s1 * vy_s1;
			p_s2[1] <= uy_s1 * vz_s1;
			p_s2[2] <= ux_s1 * vz_s1;
			p_s2[3] <= uz_s1 * vx_s1;
			p_s2[4] <= uy_s1 * vx_s1;
			p_s2[5] <= ux_s1 * vy_s1;
		end
	end

	// stage 3: cross terms as sign and magnitude
	logic signed [PW:0] cr [3];
	tun_pkg::norm_t     nc [tun_pkg::NSTG+1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr[i] = (PW+1)'(p_s2[2*i]) - (PW+1)'(p_s2[2*i+1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc[0] <= '0;
		end else if (en) begin
			nc[0].valid <= v_s2;
			for (int i = 0; i < 3; i++) begin
				nc[0].neg[i] <= cr[i][PW];
				nc[0].mag[i] <= MW'(cr[i][PW] ? -cr[i] : cr[i]);
			end
		end
	end

	// leading-zero normalizer: largest magnitude ends with its top bit at MW-1
	for (genvar g = 0; g < tun_pkg::NSTG; g++) begin : g_norm
		tun_norm_cell #(
			.SHIFT(1 << (tun_pkg::NSTG - 1 - g))
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.d     (nc[g]),
			.q     (nc[g+1])
		);
	end

	// stage 4: take the top NW bits, square
	tun_pkg::norm_t          nl;
	logic                    v_s4, degen_s4;
	logic [2:0]              neg_s4;
	logic [2:0][NW-1:0]      m_s4;
	logic [2*NW-1:0]         sq_s4 [3];
	logic [NW-1:0]           mt [3];

	assign nl = nc[tun_pkg::NSTG];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mt[i] = nl.mag[i][MW-1 -: NW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= nl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_s4 <= ((nl.mag[0] | nl.mag[1] | nl.mag[2]) == '0);
			neg_s4   <= nl.neg;
			for (int i = 0; i < 3; i++) begin
				m_s4[i]  <= mt[i];
				sq_s4[i] <= (2*NW)'(mt[i]) * (2*NW)'(mt[i]);
			end
		end
	end

	// stage 5: sum of squares into the root chain
	tun_pkg::sqrt_t sc [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc[0] <= '0;
		end else if (en) begin
			sc[0].valid <= v_s4;
			sc[0].degen <= degen_s4;
			sc[0].neg   <= neg_s4;
			sc[0].m     <= m_s4;
			sc[0].s     <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
			sc[0].r     <= '0;
			sc[0].q     <= '0;
		end
	end

	for (genvar g = 0; g < RW; g++) begin : g_sqrt
		tun_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.d     (sc[g]),
			.q     (sc[g+1])
		);
	end

	// stage 6: rounded dividend into the divider chain
	tun_pkg::sqrt_t sl;
	tun_pkg::div_t  dc [QW+1];

	assign sl = sc[RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc[0] <= '0;
		end else if (en) begin
			dc[0].valid <= sl.valid;
			dc[0].degen <= sl.degen;
			dc[0].neg   <= sl.neg;
			dc[0].len   <= sl.q;
			for (int i = 0; i < 3; i++) begin
				dc[0].rem[i] <= DVW'({sl.m[i], {tun_pkg::F{1'b0}}}) + DVW'(sl.q >> 1);
				dc[0].quo[i] <= '0;
			end
		end
	end

	for (genvar g = 0; g < QW; g++) begin : g_div
		tun_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.d     (dc[g]),
			.q     (dc[g+1])
		);
	end

	// output register: clamp, sign, degenerate
	tun_pkg::div_t  dl;
	logic [QW-1:0]  qc [3];
	logic [OW-1:0]  sv [3];

	assign dl = dc[QW];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc[i] = (dl.quo[i] > tun_pkg::ONE) ? tun_pkg::ONE : dl.quo[i];
			if (dl.degen) begin
				sv[i] = '0;
			end else if (dl.neg[i]) begin
				sv[i] = -OW'(qc[i]);
			end else begin
				sv[i] = OW'(qc[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_valid <= 1'b0;
		end else if (en) begin
			norm_valid <= dl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_data.nx         <= sv[0];
			norm_data.ny         <= sv[1];
			norm_data.nz         <= sv[2];
			norm_data.degenerate <= dl.degen;
		end
	end

endmodule

>>> tb/sv/tb_triangle_unit_normal.sv
`timescale 1ns / 100ps

module tb_triangle_unit_normal;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tri_valid = 1'b0;
	logic tri_ready;
	tun_pkg::tri_t tri_data = '0;
	logic norm_valid;
	logic norm_ready = 1'b0;
	tun_pkg::nrm_t norm_data;

	tun_pkg::tri_t pending_tris[$];
	tun_pkg::nrm_t expected_normals[$];
	int errors = 0;
	int gap_left = 0;
	int burst_left = 0;
	int hold_left = 0;
	bit in_taken = 1'b0;
	bit drain_req = 1'b0;
	bit hold_req = 1'b0;

	triangle_unit_normal dut (
		.clk(clk), .arst_n(arst_n),
		.tri_valid(tri_valid), .tri_ready(tri_ready), .tri_data(tri_data),
		.norm_valid(norm_valid), .norm_ready(norm_ready), .norm_data(norm_data)
	);

	always #4 clk = ~clk;

	function automatic logic [127:0] mag128(logic signed [127:0] v);
		return v[127] ? -v : v;
	endfunction

	function automatic logic [63:0] root64(logic [63:0] s);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic tun_pkg::nrm_t face_normal(tun_pkg::tri_t t);
		logic signed [127:0] u[3], v[3], n[3];
		logic [127:0] mg[3];
		logic [63:0] m[3], sum, len, q;
		int blen, i, b;
		tun_pkg::nrm_t r;
		u[0] = 128'(t.bx) - 128'(t.ax);
		u[1] = 128'(t.by_coord) - 128'(t.ay);
		u[2] = 128'(t.bz) - 128'(t.az);
		v[0] = 128'(t.cx) - 128'(t.ax);
		v[1] = 128'(t.cy) - 128'(t.ay);
		v[2] = 128'(t.cz) - 128'(t.az);
		n[0] = u[2] * v[1] - u[1] * v[2];
		n[1] = u[0] * v[2] - u[2] * v[0];
		n[2] = u[1] * v[0] - u[0] * v[1];
		blen = 0;
		for (i = 0; i < 3; i++) begin
			mg[i] = mag128(n[i]);
			for (b = 127; b >= 0; b--)
				if (mg[i][b]) break;
			if (b + 1 > blen) blen = b + 1;
		end
		r = '0;
		if (blen == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		sum = 0;
		for (i = 0; i < 3; i++) begin
			m[i] = (blen < 31) ? 64'(mg[i] << (31 - blen)) : 64'(mg[i] >> (blen - 31));
			sum += m[i] * m[i];
		end
		len = root64(sum);
		for (i = 0; i < 3; i++) begin
			q = ((m[i] << tun_pkg::F) + (len >> 1)) / len;
			if (q > (64'd1 << tun_pkg::F)) q = 64'd1 << tun_pkg::F;
			if (n[i][127]) q = -q;
			case (i)
				0: r.nx = q[tun_pkg::OW-1:0];
				1: r.ny = q[tun_pkg::OW-1:0];
				default: r.nz = q[tun_pkg::OW-1:0];
			endcase
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic tun_pkg::tri_t tri_from(int c[9]);
		tun_pkg::tri_t t;
		t.ax       = tun_pkg::CW'(c[0]);
		t.ay       = tun_pkg::CW'(c[1]);
		t.az       = tun_pkg::CW'(c[2]);
		t.bx       = tun_pkg::CW'(c[3]);
		t.by_coord = tun_pkg::CW'(c[4]);
		t.bz       = tun_pkg::CW'(c[5]);
		t.cx       = tun_pkg::CW'(c[6]);
		t.cy       = tun_pkg::CW'(c[7]);
		t.cz       = tun_pkg::CW'(c[8]);
		return t;
	endfunction

	function automatic tun_pkg::tri_t random_tri(int mode);
		tun_pkg::tri_t t;
		logic [15:0] s;
		t = tun_pkg::tri_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		if (mode == 1) begin
			// small coordinates, more typical meshes
			s = $urandom_range(0, 3) == 0 ? 16'h7fff : 16'h03ff;
			t.ax &= s; t.ay &= s; t.az &= s; t.bx &= s; t.by_coord &= s;
			t.bz &= s; t.cx &= s; t.cy &= s; t.cz &= s;
		end else if (mode == 2) begin
			// degenerate: C on top of B, and sometimes B on top of A
			t.cx = t.bx; t.cy = t.by_coord; t.cz = t.bz;
			if ($urandom_range(0, 1)) begin
				t.bx = t.ax; t.by_coord = t.ay; t.bz = t.az;
			end
		end
		return t;
	endfunction

	// input acceptance, sampled at the rising edge
	always @(posedge clk) begin
		in_taken = 1'b0;
		if (arst_n && tri_valid && tri_ready) begin
			expected_normals.push_back(face_normal(tri_data));
			void'(pending_tris.pop_front());
			in_taken = 1'b1;
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!tri_valid || in_taken) begin
				if (drain_req && expected_normals.size() == 0 && !tri_valid)
					drain_req <= 1'b0;
				if (gap_left > 0) gap_left--;
				if (pending_tris.size() == 0 || gap_left > 0 || drain_req) begin
					tri_valid <= 1'b0;
				end else begin
					tri_valid <= 1'b1;
					tri_data <= pending_tris[0];
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req && hold_left == 0) begin
				hold_left = 300;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				norm_ready <= 1'b0;
			end else begin
				norm_ready <= ($urandom_range(0, 255) < 64) ? 1'b1 : ($urandom_range(0, 3) != 0);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		tun_pkg::nrm_t want;
		if (arst_n && norm_valid && norm_ready) begin
			if (expected_normals.size() == 0) begin
				report_mismatch("unexpected item", 1, 0);
			end else begin
				want = expected_normals.pop_front();
				if (norm_data.nx !== want.nx) report_mismatch("nx", norm_data.nx, want.nx);
				if (norm_data.ny !== want.ny) report_mismatch("ny", norm_data.ny, want.ny);
				if (norm_data.nz !== want.nz) report_mismatch("nz", norm_data.nz, want.nz);
				if (norm_data.degenerate !== want.degenerate)
					report_mismatch("degenerate", norm_data.degenerate, want.degenerate);
			end
		end
	end

	initial begin
		tun_pkg::tri_t t;
		int c[9];
		int i;
		t = '0; pending_tris.push_back(t);
		c = '{32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768, 32767};
		pending_tris.push_back(tri_from(c));
		c = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
		pending_tris.push_back(tri_from(c));
		c = '{32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768, 32767};
		pending_tris.push_back(tri_from(c));
		c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};   pending_tris.push_back(tri_from(c));
		c = '{0, 0, 0, 0, 1, 0, 1, 0, 0};   pending_tris.push_back(tri_from(c));
		c = '{0, 0, 0, 1, 1, 0, 1, 2, 0};   pending_tris.push_back(tri_from(c));
		c = '{0, 0, 0, 1, 0, 0, 0, 0, 1};   pending_tris.push_back(tri_from(c));
		c = '{0, 0, 0, 1, 1, 1, 2, 2, 2};   pending_tris.push_back(tri_from(c));
		c = '{5, 5, 5, 5, 5, 5, 5, 5, 5};   pending_tris.push_back(tri_from(c));
		c = '{0, 0, 0, 3, 0, 0, 0, 4, 1};   pending_tris.push_back(tri_from(c));
		c = '{-32768, 0, 0, 32767, 1, 0, 0, 0, 32767};
		pending_tris.push_back(tri_from(c));
		c = '{0, 0, 0, 1, 2, 3, 1, 2, 4};   pending_tris.push_back(tri_from(c));
		for (i = 0; i < 10; i++) pending_tris.push_back(random_tri(2));
		#(8 * 12);
		arst_n = 1'b1;
		hold_req = 1'b1;
		for (i = 0; i < 700; i++) begin
			pending_tris.push_back(random_tri($urandom_range(0, 9) == 0 ? 2 :
			                                  $urandom_range(0, 1)));
			if (i == 350) begin
				wait (pending_tris.size() == 0);
				drain_req = 1'b1;
				wait (!drain_req);
				hold_req = 1'b1;
			end
		end
		wait (pending_tris.size() == 0 && !tri_valid);
		wait (expected_normals.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
src/tun_pkg.sv
src/tun_norm_cell.sv
src/tun_sqrt_cell.sv
src/tun_div_cell.sv
src/triangle_unit_normal.sv
tb/sv/tb_triangle_unit_normal.sv
